// ===== sv/bmrc_pkg.sv =====
// ============================================================================
// bmrc_pkg: shared types and constants for the bitmap range mark/check block
// Holds map geometry, action codes, CSR indexes, the transaction payloads and
// the control structs that pass between the sequencer, divider and map walker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bmrc_pkg;

   // Map geometry
   localparam int MAP_DEPTH_BYTES = 512;
   localparam int ADDR_W  = (MAP_DEPTH_BYTES > 1) ? $clog2(MAP_DEPTH_BYTES) : 1;
   localparam int USED_W  = ADDR_W + 1;   // byte count up to the depth itself
   localparam int BITS_W  = ADDR_W + 4;   // block index up to depth*8 itself
   localparam int COUNT_W = 13;           // width of the bit_count field

   // Divider geometry
   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 32;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   // Action codes
   localparam logic [2:0] ACT_SET       = 3'd0;
   localparam logic [2:0] ACT_CLEAR     = 3'd1;
   localparam logic [2:0] ACT_CHK_SET   = 3'd2;
   localparam logic [2:0] ACT_CHK_CLEAR = 3'd3;
   localparam logic [2:0] ACT_COUNT     = 3'd4;

   // CSR indexes
   localparam logic [1:0] CSR_BASE_OFFSET = 2'd0;
   localparam logic [1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [1:0] CSR_MAP_BYTES   = 2'd2;

   // CSR reset values
   localparam logic [63:0] BASE_OFFSET_RST = 64'd0;
   localparam logic [31:0] BLOCK_SIZE_RST  = 32'd4096;
   localparam logic [9:0]  MAP_BYTES_RST   = 10'd512;

   // Set bits per nibble
   localparam logic [2:0] NIBBLE_ONES [16] = '{
      3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
      3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
   };

   function automatic logic [3:0] byte_ones(input logic [7:0] b);
      byte_ones = 4'(NIBBLE_ONES[b[3:0]]) + 4'(NIBBLE_ONES[b[7:4]]);
   endfunction

   // Transaction payloads
   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] req_offset;
      logic [31:0] req_length;
   } req_payload_type;

   typedef struct packed {
      logic               status;
      logic               range_matches;
      logic [COUNT_W-1:0] bit_count;
   } rsp_payload_type;

   // Divider control
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic                  rem_nz;
   } div_sts_type;

   // Map walker control
   typedef struct packed {
      logic              start;
      logic [2:0]        op;
      logic [ADDR_W-1:0] start_byte;
      logic [ADDR_W-1:0] last_byte;
      logic [BITS_W-1:0] start_blk;
      logic [BITS_W-1:0] end_blk;
   } walk_cmd_type;

   typedef struct packed {
      logic               ready;
      logic               done;
      logic               all_hit;
      logic [COUNT_W-1:0] count;
   } walk_sts_type;

endpackage

`default_nettype wire

// ===== sv/bmrc_divider.sv =====
// ============================================================================
// bmrc_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle, 64-bit dividend by 32-bit
// divisor. Reports the quotient and whether the remainder is nonzero.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bmrc_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bmrc_pkg::div_req_type req,
   output bmrc_pkg::div_sts_type     sts
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [bmrc_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [bmrc_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   logic [bmrc_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [bmrc_pkg::DIVISOR_W-1:0]     dvs_ff, dvs_in;
   logic [bmrc_pkg::DIVISOR_W:0]       trial;
   logic [bmrc_pkg::DIVISOR_W:0]       diff;
   logic                               qbit;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[bmrc_pkg::DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      qbit  = (trial >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (busy_ff) begin
         quo_in = {quo_ff[bmrc_pkg::DIVIDEND_W-2:0], qbit};
         rem_in = qbit ? diff[bmrc_pkg::DIVISOR_W-1:0] : trial[bmrc_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bmrc_pkg::DIV_CNT_W'(bmrc_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;
   assign sts.rem_nz   = (rem_ff != '0);

endmodule

`default_nettype wire

// ===== sv/bmrc_walker.sv =====
// ============================================================================
// bmrc_walker: bitmap memory and byte walker
// Owns the bitmap RAM. Clears it after reset, then walks a byte range with
// read, modify and write-back, one byte per cycle, to set, clear, test or
// count bits.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bmrc_walker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bmrc_pkg::walk_cmd_type cmd,
   output bmrc_pkg::walk_sts_type     sts
);

   typedef enum logic [3:0] {
      W_CLEAR = 4'b0001,
      W_IDLE  = 4'b0010,
      W_RUN   = 4'b0100,
      W_DRAIN = 4'b1000
   } wstate_type;

   wstate_type                          wstate_ff, wstate_in;
   logic [bmrc_pkg::ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   logic [bmrc_pkg::ADDR_W-1:0]         rd_addr_ff, rd_addr_in;
   logic [bmrc_pkg::ADDR_W-1:0]         last_ff, last_in;
   logic [2:0]                          op_ff, op_in;
   logic [bmrc_pkg::BITS_W-1:0]         start_blk_ff, start_blk_in;
   logic [bmrc_pkg::BITS_W-1:0]         end_blk_ff, end_blk_in;
   logic                                s1_valid_ff, s1_valid_in;
   logic [bmrc_pkg::ADDR_W-1:0]         s1_addr_ff, s1_addr_in;
   logic                                match_ff, match_in;
   logic [bmrc_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                                done_ff, done_in;
   logic [7:0]                          rd_data_ff;

   logic [7:0]                          mem [bmrc_pkg::MAP_DEPTH_BYTES];

   logic                                rd_en;
   logic                                wr_en;
   logic [bmrc_pkg::ADDR_W-1:0]         wr_addr;
   logic [7:0]                          wr_data;
   logic [7:0]                          mask;
   logic [bmrc_pkg::BITS_W-1:0]         blk;

   // Bits of the current byte that fall inside [start_blk, end_blk); MSB first
   always_comb begin
      blk  = '0;
      mask = '0;
      for (int p = 0; p < 8; p++) begin
         blk = bmrc_pkg::BITS_W'({s1_addr_ff, 3'(p)});
         mask[7-p] = (blk >= start_blk_ff) && (blk < end_blk_ff);
      end
   end

   // Sequencer and stage-1 modify
   always_comb begin
      wstate_in    = wstate_ff;
      clr_addr_in  = clr_addr_ff;
      rd_addr_in   = rd_addr_ff;
      last_in      = last_ff;
      op_in        = op_ff;
      start_blk_in = start_blk_ff;
      end_blk_in   = end_blk_ff;
      s1_valid_in  = 1'b0;
      s1_addr_in   = rd_addr_ff;
      match_in     = match_ff;
      count_in     = count_ff;
      done_in      = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = s1_addr_ff;
      wr_data      = rd_data_ff;

      unique case (wstate_ff)
         W_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == bmrc_pkg::ADDR_W'(bmrc_pkg::MAP_DEPTH_BYTES - 1)) begin
               wstate_in = W_IDLE;
            end
         end
         W_IDLE: begin
            if (cmd.start) begin
               rd_addr_in   = cmd.start_byte;
               last_in      = cmd.last_byte;
               op_in        = cmd.op;
               start_blk_in = cmd.start_blk;
               end_blk_in   = cmd.end_blk;
               match_in     = 1'b1;
               count_in     = '0;
               wstate_in    = W_RUN;
            end
         end
         W_RUN: begin
            rd_en       = 1'b1;
            s1_valid_in = 1'b1;
            rd_addr_in  = rd_addr_ff + 1'b1;
            if (rd_addr_ff == last_ff) begin
               wstate_in = W_DRAIN;
            end
         end
         W_DRAIN: begin
            done_in   = 1'b1;
            wstate_in = W_IDLE;
         end
         default: begin
            wstate_in = W_IDLE;
         end
      endcase

      // Stage 1: read data is back; modify, write back, accumulate
      if (s1_valid_ff) begin
         case (op_ff)
            bmrc_pkg::ACT_SET: begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff | mask;
            end
            bmrc_pkg::ACT_CLEAR: begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff & ~mask;
            end
            bmrc_pkg::ACT_CHK_SET: begin
               if ((rd_data_ff & mask) != mask) match_in = 1'b0;
            end
            bmrc_pkg::ACT_CHK_CLEAR: begin
               if ((rd_data_ff & mask) != 8'h00) match_in = 1'b0;
            end
            bmrc_pkg::ACT_COUNT: begin
               count_in = count_ff + bmrc_pkg::COUNT_W'(bmrc_pkg::byte_ones(rd_data_ff));
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wstate_ff   <= W_CLEAR;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         wstate_ff   <= wstate_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= s1_valid_in;
         done_ff     <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      last_ff      <= last_in;
      op_ff        <= op_in;
      start_blk_ff <= start_blk_in;
      end_blk_ff   <= end_blk_in;
      s1_addr_ff   <= s1_addr_in;
      match_ff     <= match_in;
      count_ff     <= count_in;
   end

   // Bitmap RAM: one write port, one registered read port.
   // Reads walk upward, so a read never hits the byte being written back.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   assign sts.ready   = (wstate_ff == W_IDLE);
   assign sts.done    = done_ff;
   assign sts.all_hit = match_ff;
   assign sts.count   = count_ff;

endmodule

`default_nettype wire

// ===== sv/bitmap_range_mark_check.sv =====
// ============================================================================
// bitmap_range_mark_check: block-granular bitmap range mark and check
// Converts a byte range to a block range, bounds-checks it against the map,
// then sets, clears, tests or counts bits through the bitmap RAM walker.
// ============================================================================
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   req     | in        | req_valid / req_stall | action, offset, length
//   rsp     | out       | rsp_valid / rsp_stall | status, matches, bit_count
//   csr     | in        | csr_write_en          | csr_index, csr_wdata
//
// From request acceptance to rsp_valid, with the output register free, range
// actions run two divisions, the bounds check and a walk over each bitmap byte
// touched; out-of-range and zero-length ranges end at the bounds check; the
// count action walks the bytes in use; below-base and unknown actions go straight to done.
// Each result returns the sequencer to idle before the next request is taken.
// After reset the bitmap RAM is cleared byte by byte; req_stall stays high.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only the result load waits on rsp_stall.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bitmap_range_mark_check (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire bmrc_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output bmrc_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_write_en,
   input  wire logic [1:0]                csr_index,
   input  wire logic [63:0]               csr_wdata
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_PREP    = 7'b0000010,
      S_DIV_OFS = 7'b0000100,
      S_DIV_LEN = 7'b0001000,
      S_CHECK   = 7'b0010000,
      S_WALK    = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [2:0]                      act_ff, act_in;
   logic [63:0]                     ofs_ff, ofs_in;
   logic [31:0]                     len_ff, len_in;
   logic [63:0]                     first_ff, first_in;
   logic [32:0]                     num_ff, num_in;
   logic                            res_status_ff, res_status_in;
   logic                            res_match_ff, res_match_in;
   logic [bmrc_pkg::COUNT_W-1:0]    res_count_ff, res_count_in;
   logic [63:0]                     base_ff;
   logic [31:0]                     bsize_ff;
   logic [9:0]                      mapb_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   bmrc_pkg::rsp_payload_type       rsp_payload_ff;

   bmrc_pkg::div_req_type           div_req;
   bmrc_pkg::div_sts_type           div_sts;
   bmrc_pkg::walk_cmd_type          walk_cmd;
   bmrc_pkg::walk_sts_type          walk_sts;

   logic                            req_take;
   logic                            rsp_load;
   logic                            is_check;
   logic [bmrc_pkg::USED_W-1:0]     used_bytes;
   logic [bmrc_pkg::BITS_W-1:0]     total_bits;
   logic [31:0]                     bs_eff;
   logic [bmrc_pkg::BITS_W-1:0]     room;
   logic [bmrc_pkg::BITS_W-1:0]     end_blk;
   logic [bmrc_pkg::BITS_W-1:0]     end_m1;

   // Effective map size and block size
   assign used_bytes = (32'(mapb_ff) > 32'(bmrc_pkg::MAP_DEPTH_BYTES)) ?
                       bmrc_pkg::USED_W'(bmrc_pkg::MAP_DEPTH_BYTES) :
                       bmrc_pkg::USED_W'(mapb_ff);
   assign total_bits = {used_bytes, 3'b000};
   assign bs_eff     = (bsize_ff == 32'd0) ? 32'd1 : bsize_ff;
   assign is_check   = (act_ff == bmrc_pkg::ACT_CHK_SET) ||
                       (act_ff == bmrc_pkg::ACT_CHK_CLEAR);

   // Block range arithmetic, valid once first is known to be within the map
   assign room    = total_bits - first_ff[bmrc_pkg::BITS_W-1:0];
   assign end_blk = first_ff[bmrc_pkg::BITS_W-1:0] + num_ff[bmrc_pkg::BITS_W-1:0];
   assign end_m1  = end_blk - 1'b1;

   assign req_stall = (state_ff != S_IDLE) || !walk_sts.ready;
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Request sequencer
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      ofs_in        = ofs_ff;
      len_in        = len_ff;
      first_in      = first_ff;
      num_in        = num_ff;
      res_status_in = res_status_ff;
      res_match_in  = res_match_ff;
      res_count_in  = res_count_ff;

      div_req          = '0;
      div_req.divisor  = bs_eff;
      walk_cmd         = '0;
      walk_cmd.op      = act_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in        = req_payload.action;
               ofs_in        = req_payload.req_offset;
               len_in        = req_payload.req_length;
               res_status_in = 1'b0;
               res_match_in  = 1'b0;
               res_count_in  = '0;
               state_in      = S_PREP;
            end
         end
         S_PREP: begin
            if (act_ff == bmrc_pkg::ACT_COUNT) begin
               if (used_bytes == '0) begin
                  state_in = S_DONE;
               end else begin
                  walk_cmd.start      = 1'b1;
                  walk_cmd.start_byte = '0;
                  walk_cmd.last_byte  = bmrc_pkg::ADDR_W'(used_bytes - 1'b1);
                  walk_cmd.start_blk  = '0;
                  walk_cmd.end_blk    = total_bits;
                  state_in            = S_WALK;
               end
            end else if (act_ff > bmrc_pkg::ACT_COUNT) begin
               state_in = S_DONE;
            end else if (ofs_ff < base_ff) begin
               res_status_in = 1'b1;
               state_in      = S_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = ofs_ff - base_ff;
               state_in         = S_DIV_OFS;
            end
         end
         S_DIV_OFS: begin
            if (div_sts.done) begin
               first_in         = div_sts.quotient;
               div_req.start    = 1'b1;
               div_req.dividend = {32'd0, len_ff};
               state_in         = S_DIV_LEN;
            end
         end
         S_DIV_LEN: begin
            if (div_sts.done) begin
               num_in   = div_sts.quotient[32:0] + 33'(div_sts.rem_nz);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if ((first_ff > 64'(total_bits)) || (num_ff > 33'(room))) begin
               res_status_in = 1'b1;
               state_in      = S_DONE;
            end else if (num_ff == '0) begin
               res_match_in = is_check;
               state_in     = S_DONE;
            end else begin
               walk_cmd.start      = 1'b1;
               walk_cmd.start_byte = first_ff[bmrc_pkg::ADDR_W+2:3];
               walk_cmd.last_byte  = end_m1[bmrc_pkg::ADDR_W+2:3];
               walk_cmd.start_blk  = first_ff[bmrc_pkg::BITS_W-1:0];
               walk_cmd.end_blk    = end_blk;
               state_in            = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_sts.done) begin
               res_match_in = is_check && walk_sts.all_hit;
               res_count_in = (act_ff == bmrc_pkg::ACT_COUNT) ? walk_sts.count : '0;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      ofs_ff        <= ofs_in;
      len_ff        <= len_in;
      first_ff      <= first_in;
      num_ff        <= num_in;
      res_status_ff <= res_status_in;
      res_match_ff  <= res_match_in;
      res_count_ff  <= res_count_in;
      if (rsp_load) begin
         rsp_payload_ff.status        <= res_status_ff;
         rsp_payload_ff.range_matches <= res_match_ff;
         rsp_payload_ff.bit_count     <= res_count_ff;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= bmrc_pkg::BASE_OFFSET_RST;
         bsize_ff <= bmrc_pkg::BLOCK_SIZE_RST;
         mapb_ff  <= bmrc_pkg::MAP_BYTES_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bmrc_pkg::CSR_BASE_OFFSET: base_ff  <= csr_wdata;
            bmrc_pkg::CSR_BLOCK_SIZE:  bsize_ff <= csr_wdata[31:0];
            bmrc_pkg::CSR_MAP_BYTES:   mapb_ff  <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   bmrc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .sts   (div_sts)
   );

   bmrc_walker u_walker (
      .clock (clock),
      .reset (reset),
      .cmd   (walk_cmd),
      .sts   (walk_sts)
   );

`ifndef SYNTHESIS
   // An accepted transaction always leaves idle
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // A finished result is loaded into the output register
   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result load did not raise rsp_valid");

   // The walker is only started when it is idle
   a_walk_start_ready: assert property (@(posedge clock) disable iff (reset)
      walk_cmd.start |-> walk_sts.ready)
      else $error("walker started while busy");

   // The divider is only started when it is free
   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_sts.busy)
      else $error("divider started while busy");
`endif

endmodule

`default_nettype wire
